>>> rtl/running_median_two_heaps_assert.svh
// assertion macros for the running median block
// depends on nothing; included by the top level
`ifndef RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge out of reset
`define RMTH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// expression must never be true out of reset
`define RMTH_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define RMTH_ASSERT(lbl, clk, rstn, prop, msg)
`define RMTH_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

>>> rtl/rmth_pkg.sv
// package for the running median block: field widths and parameter defaults
// no dependencies
package rmth_pkg;
  localparam int SAMPLE_IN_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W = 10;
  localparam int MAX_SAMPLES_DEF = 512;
  localparam int SAMPLE_WIDTH_DEF = 32;
endpackage

>>> rtl/running_median_two_heaps.sv
// running median over two heaps sharing one single-port memory
// depends on rmth_pkg and running_median_two_heaps_assert.svh
//
//   channel  | direction | handshake            | payload
//   in       | input     | in_valid_i/in_stall_o | in_sample_i
//   out      | output    | out_valid_o/out_stall_i | median_doubled, sample_count, dropped
//
// a push sifts up through S_PU_RD and S_PU_CMP, a replace-top sifts down through
// S_RT_RDL, S_RT_RDR and S_RT_CMP; an item that rebalances does a replace-top
// then a push, and every item ends in S_FIN
// the single memory port and its registered read set the pace, one heap level per step
// reset empties both heaps by clearing the counts; heap memory is not cleared
// a new item is taken only while the sequencer is idle; a stalled result holds
`include "running_median_two_heaps_assert.svh"
module running_median_two_heaps #(
  parameter int MAX_SAMPLES = rmth_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_WIDTH = rmth_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [rmth_pkg::SAMPLE_IN_W-1:0] in_sample_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [rmth_pkg::MEDIAN_W-1:0] out_median_doubled_o,
  output logic [rmth_pkg::COUNT_W-1:0] out_sample_count_o,
  output logic out_dropped_o
);
  import rmth_pkg::*;

  localparam int HD = (MAX_SAMPLES + 1) / 2;
  localparam int IW = (HD > 1) ? $clog2(HD) : 1;
  localparam int NW = $clog2(HD + 1);
  localparam int TW = NW + 1;
  localparam int CW = IW + 2;
  localparam int AW = IW + 1;
  localparam int SW = SAMPLE_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE, S_PU_RD, S_PU_CMP, S_RT_RDL, S_RT_RDR, S_RT_CMP, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic [NW-1:0] lcnt_q, lcnt_d, ucnt_q, ucnt_d;
  logic signed [SW-1:0] ltop_q, ltop_d, utop_q, utop_d;
  logic signed [SW-1:0] val_q, val_d, pend_q, pend_d, best_q, best_d;
  logic sel_q, sel_d, pend_vld_q, pend_vld_d, drop_q, drop_d;
  logic bleft_q, bleft_d, rok_q, rok_d;
  logic [IW-1:0] idx_q, idx_d;
  logic out_valid_q, out_valid_d;
  logic signed [MEDIAN_W-1:0] med_q, med_d;
  logic [COUNT_W-1:0] cnt_out_q, cnt_out_d;
  logic drop_out_q, drop_out_d;

  // shared heap memory, upper half of the address space holds the min-heap
  logic signed [SW-1:0] mem [2**AW];
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic signed [SW-1:0] mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  // heap order: max-heap for the lower half, min-heap for the upper half
  function automatic logic goes_first(logic signed [SW-1:0] a, logic signed [SW-1:0] b,
                                      logic is_min);
    return is_min ? (a < b) : (a > b);
  endfunction

  logic signed [SW-1:0] smp;
  logic [TW-1:0] total;
  logic [CW-1:0] lchild, rchild, ncur;
  logic [IW-1:0] parent;
  logic [31:0] total32;
  logic signed [MEDIAN_W-1:0] lt_ext, ut_ext;
  logic bal_ok;

  assign smp = in_sample_i[SW-1:0];
  assign total = TW'(lcnt_q) + TW'(ucnt_q);
  assign total32 = 32'(total);
  assign lchild = {1'b0, idx_q, 1'b1};
  assign rchild = lchild + CW'(1);
  assign ncur = sel_q ? CW'(ucnt_q) : CW'(lcnt_q);
  assign parent = (idx_q - IW'(1)) >> 1;
  assign lt_ext = MEDIAN_W'(ltop_q);
  assign ut_ext = MEDIAN_W'(utop_q);

  // halves differ by at most one
  assign bal_ok = (lcnt_q == ucnt_q) || (lcnt_q == ucnt_q + NW'(1)) ||
                  (ucnt_q == lcnt_q + NW'(1));

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_median_doubled_o = med_q;
  assign out_sample_count_o = cnt_out_q;
  assign out_dropped_o = drop_out_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    lcnt_d = lcnt_q;
    ucnt_d = ucnt_q;
    ltop_d = ltop_q;
    utop_d = utop_q;
    val_d = val_q;
    pend_d = pend_q;
    best_d = best_q;
    sel_d = sel_q;
    pend_vld_d = pend_vld_q;
    drop_d = drop_q;
    bleft_d = bleft_q;
    rok_d = rok_q;
    idx_d = idx_q;
    out_valid_d = out_valid_q & out_stall_i;
    med_d = med_q;
    cnt_out_d = cnt_out_q;
    drop_out_d = drop_out_q;
    mem_we = 1'b0;
    mem_addr = {sel_q, idx_q};
    mem_wdata = val_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          drop_d = 1'b0;
          pend_vld_d = 1'b0;
          state_d = S_PU_RD;
          val_d = smp;
          if (total >= TW'(MAX_SAMPLES)) begin
            drop_d = 1'b1;
            state_d = S_FIN;
          end else if (total == '0) begin
            sel_d = 1'b0;
          end else if (lcnt_q == ucnt_q) begin
            sel_d = (smp >= utop_q) && (smp > ltop_q);
          end else if (lcnt_q > ucnt_q) begin
            sel_d = 1'b1;
            if (smp < ltop_q) begin
              sel_d = 1'b0;
              pend_d = ltop_q;
              pend_vld_d = 1'b1;
              state_d = S_RT_RDL;
            end
          end else begin
            sel_d = 1'b0;
            if (smp > utop_q) begin
              sel_d = 1'b1;
              pend_d = utop_q;
              pend_vld_d = 1'b1;
              state_d = S_RT_RDL;
            end
          end
          // a push starts at the tail, a replace at the root
          if (state_d == S_PU_RD) begin
            if (sel_d) begin
              idx_d = IW'(ucnt_q);
              ucnt_d = ucnt_q + NW'(1);
            end else begin
              idx_d = IW'(lcnt_q);
              lcnt_d = lcnt_q + NW'(1);
            end
          end else begin
            idx_d = '0;
          end
        end
      end
      S_PU_RD: begin
        if (idx_q == '0) begin
          mem_we = 1'b1;
          state_d = S_FIN;
        end else begin
          mem_addr = {sel_q, parent};
          state_d = S_PU_CMP;
        end
      end
      S_PU_CMP: begin
        if (goes_first(val_q, mem_rdata_q, sel_q)) begin
          mem_we = 1'b1;
          mem_wdata = mem_rdata_q;
          idx_d = parent;
          state_d = S_PU_RD;
        end else begin
          mem_we = 1'b1;
          state_d = S_FIN;
        end
      end
      S_RT_RDL: begin
        if (lchild < ncur) begin
          mem_addr = {sel_q, lchild[IW-1:0]};
          state_d = S_RT_RDR;
        end else begin
          mem_we = 1'b1;
          state_d = S_FIN;
        end
      end
      S_RT_RDR: begin
        bleft_d = goes_first(mem_rdata_q, val_q, sel_q);
        best_d = bleft_d ? mem_rdata_q : val_q;
        rok_d = rchild < ncur;
        mem_addr = {sel_q, rchild[IW-1:0]};
        state_d = S_RT_CMP;
      end
      S_RT_CMP: begin
        mem_we = 1'b1;
        if (rok_q && goes_first(mem_rdata_q, best_q, sel_q)) begin
          mem_wdata = mem_rdata_q;
          idx_d = rchild[IW-1:0];
          state_d = S_RT_RDL;
        end else if (bleft_q) begin
          mem_wdata = best_q;
          idx_d = lchild[IW-1:0];
          state_d = S_RT_RDL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (pend_vld_q) begin
          // move the old top across to the other half
          pend_vld_d = 1'b0;
          sel_d = ~sel_q;
          val_d = pend_q;
          state_d = S_PU_RD;
          if (sel_q) begin
            idx_d = IW'(lcnt_q);
            lcnt_d = lcnt_q + NW'(1);
          end else begin
            idx_d = IW'(ucnt_q);
            ucnt_d = ucnt_q + NW'(1);
          end
        end else if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          drop_out_d = drop_q;
          cnt_out_d = total32[COUNT_W-1:0];
          if (total == '0) begin
            med_d = '0;
          end else if (lcnt_q > ucnt_q) begin
            med_d = lt_ext <<< 1;
          end else if (ucnt_q > lcnt_q) begin
            med_d = ut_ext <<< 1;
          end else begin
            med_d = lt_ext + ut_ext;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // root writes refresh the cached tops
    if (mem_we && mem_addr[IW-1:0] == '0) begin
      if (mem_addr[AW-1]) begin
        utop_d = mem_wdata;
      end else begin
        ltop_d = mem_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lcnt_q <= '0;
      ucnt_q <= '0;
      pend_vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q <= lcnt_d;
      ucnt_q <= ucnt_d;
      pend_vld_q <= pend_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ltop_q <= ltop_d;
    utop_q <= utop_d;
    val_q <= val_d;
    pend_q <= pend_d;
    best_q <= best_d;
    sel_q <= sel_d;
    drop_q <= drop_d;
    bleft_q <= bleft_d;
    rok_q <= rok_d;
    idx_q <= idx_d;
    med_q <= med_d;
    cnt_out_q <= cnt_out_d;
    drop_out_q <= drop_out_d;
  end

  // checks
  `RMTH_NEVER(a_total_max, clk_i, rst_ni, total > TW'(MAX_SAMPLES), "sample count above limit")
  `RMTH_ASSERT(a_balance, clk_i, rst_ni, (state_q == S_IDLE) |-> bal_ok, "heap halves out of balance")
  `RMTH_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_median_doubled_o)), "stalled result changed")
endmodule

>>> tb/tb_running_median_two_heaps.sv
// self-checking testbench for running_median_two_heaps: random and directed samples
// depends on rmth_pkg and the running_median_two_heaps rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_running_median_two_heaps;
  import rmth_pkg::*;

  localparam int CAP = MAX_SAMPLES_DEF;
  localparam int HALF = (CAP + 1) / 2;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median;
    logic [COUNT_W-1:0] count;
    logic dropped;
  } median_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMPLE_IN_W-1:0] in_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [MEDIAN_W-1:0] out_median_doubled_o;
  logic [COUNT_W-1:0] out_sample_count_o;
  logic out_dropped_o;

  running_median_two_heaps dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: two heaps of the stored samples
  int lo_heap[HALF];
  int hi_heap[HALF];
  int lo_n, hi_n;

  logic [SAMPLE_IN_W-1:0] sample_q[$];
  median_res_t median_exp_q[$];
  int send_idle_pct, recv_idle_pct;
  bit drain_hold;
  int errors;
  int wdog;

  function automatic bit ahead(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic push_lo(int v);
    int i, p, t;
    i = lo_n;
    lo_heap[i] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ahead(lo_heap[i], lo_heap[p], 1'b1)) break;
      t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
      i = p;
    end
    lo_n++;
  endtask

  task automatic push_hi(int v);
    int i, p, t;
    i = hi_n;
    hi_heap[i] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ahead(hi_heap[i], hi_heap[p], 1'b0)) break;
      t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
      i = p;
    end
    hi_n++;
  endtask

  // replace the top and sift down; is_max selects the lower half
  task automatic swap_top(bit is_max, int v);
    int i, l, r, b, t, n;
    n = is_max ? lo_n : hi_n;
    i = 0;
    if (is_max) lo_heap[0] = v; else hi_heap[0] = v;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      b = i;
      if (is_max) begin
        if (l < n && lo_heap[l] > lo_heap[b]) b = l;
        if (r < n && lo_heap[r] > lo_heap[b]) b = r;
        if (b == i) break;
        t = lo_heap[i]; lo_heap[i] = lo_heap[b]; lo_heap[b] = t;
      end else begin
        if (l < n && hi_heap[l] < hi_heap[b]) b = l;
        if (r < n && hi_heap[r] < hi_heap[b]) b = r;
        if (b == i) break;
        t = hi_heap[i]; hi_heap[i] = hi_heap[b]; hi_heap[b] = t;
      end
      i = b;
    end
  endtask

  task automatic predict_median(logic [SAMPLE_IN_W-1:0] raw);
    int s, top;
    median_res_t r;
    longint m;
    s = int'(raw);
    r.dropped = 1'b0;
    if (lo_n + hi_n >= CAP) begin
      r.dropped = 1'b1;
    end else if (lo_n + hi_n == 0) begin
      push_lo(s);
    end else if (lo_n == hi_n) begin
      if (s >= hi_heap[0] && s > lo_heap[0]) push_hi(s);
      else push_lo(s);
    end else if (lo_n > hi_n) begin
      top = lo_heap[0];
      if (s >= top) push_hi(s);
      else begin
        swap_top(1'b1, s);
        push_hi(top);
      end
    end else begin
      top = hi_heap[0];
      if (s <= top) push_lo(s);
      else begin
        swap_top(1'b0, s);
        push_lo(top);
      end
    end
    if (lo_n + hi_n == 0) m = 0;
    else if (lo_n > hi_n) m = 2 * longint'(lo_heap[0]);
    else if (hi_n > lo_n) m = 2 * longint'(hi_heap[0]);
    else m = longint'(lo_heap[0]) + longint'(hi_heap[0]);
    r.median = m[MEDIAN_W-1:0];
    r.count = COUNT_W'(lo_n + hi_n);
    median_exp_q.push_back(r);
  endtask

  // driver: one sample per transfer, random idle cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_median(in_sample_i);
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i && !in_stall_o) void'(sample_q.pop_front());
        if (sample_q.size() > 0 && !drain_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_sample_i <= sample_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    median_res_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
      else wdog <= wdog + 1;
      if (out_valid_o && !out_stall_i) begin
        if (median_exp_q.size() == 0) begin
          $display("%0t: unexpected result median %0d count %0d dropped %0b", $time,
                   out_median_doubled_o, out_sample_count_o, out_dropped_o);
          errors++;
        end else begin
          e = median_exp_q.pop_front();
          if (out_median_doubled_o !== e.median) begin
            $display("%0t: median_doubled expected %0d actual %0d", $time, e.median,
                     out_median_doubled_o);
            errors++;
          end
          if (out_sample_count_o !== e.count) begin
            $display("%0t: sample_count expected %0d actual %0d", $time, e.count,
                     out_sample_count_o);
            errors++;
          end
          if (out_dropped_o !== e.dropped) begin
            $display("%0t: dropped expected %0b actual %0b", $time, e.dropped,
                     out_dropped_o);
            errors++;
          end
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("tb_running_median_two_heaps: FAIL");
        $finish;
      end
    end
  end

  // random sample: half from narrow ranges so duplicates and ties occur, the rest full-range or large
  function automatic logic [SAMPLE_IN_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return SAMPLE_IN_W'($signed($urandom_range(40)) - 20);
      2: return {$urandom_range(1) ? 2'b10 : 2'b01, 30'($urandom)};
      default: return SAMPLE_IN_W'($signed($urandom_range(2000)) - 1000);
    endcase
  endfunction

  task automatic wait_empty();
    while (sample_q.size() > 0 || in_valid_i || median_exp_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // reset the block once: the sample store fills and is never emptied, so later samples are dropped
  initial begin
    lo_n = 0;
    hi_n = 0;
    errors = 0;
    wdog = 0;
    drain_hold = 1'b0;
    send_idle_pct = 37;
    recv_idle_pct = 53;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty, extremes, ties, odd/even, half-integer sums
    sample_q.push_back(32'h7fffffff);
    sample_q.push_back(32'h80000000);
    sample_q.push_back(32'h80000000);
    sample_q.push_back(32'h7fffffff);
    sample_q.push_back(32'h7fffffff);
    sample_q.push_back(32'd0);
    sample_q.push_back(32'd5);
    sample_q.push_back(32'hffffffff);
    sample_q.push_back(32'd3);
    sample_q.push_back(32'd3);
    sample_q.push_back(32'd4);
    sample_q.push_back(32'h55555555);
    sample_q.push_back(32'haaaaaaaa);
    wait_empty();

    // hold back new samples for a pause; every expected result has already come
    drain_hold = 1'b1;
    repeat (20) @(posedge clk_i);
    drain_hold = 1'b0;

    // random fill past capacity so drops are exercised, in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 37 : 0;
      for (int k = 0; k < 600; k++) sample_q.push_back(rand_sample());
      wait_empty();
    end

    if (errors == 0) $display("tb_running_median_two_heaps: PASS");
    else $display("tb_running_median_two_heaps: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
